>>> rtl/core/pctbl_pkg.sv
// shared types and constants of the per-client token bucket limiter
package pctbl_pkg;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [31:0] tokens;
    logic [47:0] refill_time;
    logic [47:0] seen_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // shared divider widths
  localparam int DIVD_W = 42;
  localparam int DIVS_W = 32;

  // operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_CLEANUP = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_RATE   = 2'd1;
  localparam logic [1:0] CFG_BURST  = 2'd2;
  localparam logic [1:0] CFG_MAXENT = 2'd3;

  // fixed-point constants
  localparam logic [32:0] ONE_TOKEN    = 33'h1_0000;
  // ceil(2^46 / 125): y * MS_RECIP >> 46 is floor(y / 125) for y below 2^39
  localparam logic [39:0] MS_RECIP     = 40'd562949953422;
  localparam logic [63:0] REFILL_LIMIT = 64'd1000 << 32;
  localparam logic [7:0]  MAX_ENT_RST  = 8'd64;

endpackage

>>> rtl/core/pctbl_ram.sv
// generic single-write single-read ram with registered read data
module pctbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/pctbl_div.sv
// iterative restoring divider, one quotient bit per cycle
module pctbl_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pctbl_pkg::DIVD_W-1:0]   dividend,
  input  logic [pctbl_pkg::DIVS_W-1:0]   divisor,
  output logic                           busy,
  output logic                           done,
  output logic [pctbl_pkg::DIVD_W-1:0]   quotient
);
  import pctbl_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W:0]   rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIVS_W:0]   rem_sh;

  // one shift-and-subtract step per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[DIVS_W-1:0], quo_r[DIVD_W-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  // divider never restarts mid-division
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");

endmodule

>>> rtl/core/per_client_token_bucket_limiter.sv
// per-client token bucket limiter: one item at a time, entries kept in one memory
// an enabled request takes a table sweep, plus refill steps when the bucket refills
// (product, then scaling by 1/1000), plus a retry division (one bit a cycle);
// cleanup takes a stale sweep, then one more sweep per trimmed entry; the next item
// is taken once the previous result is in the output register; synchronous active-low
// reset clears valid bits, fill count, cleanup time and config, with max entries at 64
module per_client_token_bucket_limiter #(
  parameter int TABLE_DEPTH       = 64,
  parameter int STALE_LIMIT_MS    = 300000,
  parameter int CLEANUP_PERIOD_MS = 30000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [63:0] in_client_key_high,
  input  logic [63:0] in_client_key_low,
  input  logic [47:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_allowed,
  output logic [15:0] out_retry_after_s,
  output logic [15:0] out_remaining_tokens,
  output logic [21:0] out_limit_per_minute,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pctbl_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LIM_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_PLACE    = 4'd2;
  localparam logic [3:0] S_REF      = 4'd3;
  localparam logic [3:0] S_MUL      = 4'd4;
  localparam logic [3:0] S_ADIV     = 4'd5;
  localparam logic [3:0] S_AWAIT    = 4'd6;
  localparam logic [3:0] S_TOK      = 4'd7;
  localparam logic [3:0] S_RWAIT    = 4'd8;
  localparam logic [3:0] S_WB       = 4'd9;
  localparam logic [3:0] S_CL_STALE = 4'd10;
  localparam logic [3:0] S_CL_CHK   = 4'd11;
  localparam logic [3:0] S_CL_TRIM  = 4'd12;
  localparam logic [3:0] S_CL_EVICT = 4'd13;
  localparam logic [3:0] S_DONE     = 4'd14;

  // control and config registers
  logic [3:0]             state_r, state_nxt;
  logic                   iss_on_r, iss_on_nxt;
  logic [IDX_W-1:0]       iss_idx_r, iss_idx_nxt;
  logic                   rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [47:0]            last_cl_r, last_cl_nxt;
  logic                   enable_r, enable_nxt;
  logic [31:0]            rate_r, rate_nxt;
  logic [15:0]            burst_r, burst_nxt;
  logic [6:0]             maxent_r, maxent_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // datapath registers
  logic [63:0]      kh_r, kh_nxt, kl_r, kl_nxt;
  logic [47:0]      now_r, now_nxt;
  logic             mhit_r, mhit_nxt;
  logic [IDX_W-1:0] midx_r, midx_nxt;
  entry_t           ment_r, ment_nxt;
  logic             ohit_r, ohit_nxt;
  logic [IDX_W-1:0] oidx_r, oidx_nxt;
  logic [47:0]      oseen_r, oseen_nxt;
  logic             fhit_r, fhit_nxt;
  logic [IDX_W-1:0] fidx_r, fidx_nxt;
  entry_t           ent_r, ent_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             new_r, new_nxt;
  logic             refl_r, refl_nxt;
  logic [47:0]      dm_r, dm_nxt;
  logic [79:0]      prod_r, prod_nxt;
  logic [1:0]       mstep_r, mstep_nxt;
  logic [31:0]      add_r, add_nxt;
  logic             res_allowed_r, res_allowed_nxt;
  logic [15:0]      res_retry_r, res_retry_nxt;
  logic [15:0]      res_rem_r, res_rem_nxt;
  logic             res_lpm_r, res_lpm_nxt;
  logic             out_allowed_r, out_allowed_nxt;
  logic [15:0]      out_retry_r, out_retry_nxt;
  logic [15:0]      out_rem_r, out_rem_nxt;
  logic [21:0]      out_lpm_r, out_lpm_nxt;

  // memory and divider hookup
  entry_t            rd_ent;
  logic [ENTRY_W-1:0] rd_data;
  logic              ram_we;
  logic              div_start, div_busy, div_done;
  logic [DIVD_W-1:0] div_dividend, div_quot;
  logic [DIVS_W-1:0] div_divisor;

  // scratch values
  logic [31:0]      cap;
  logic [37:0]      lpm_full;
  logic             rd_v, scan_last, evict;
  logic [LIM_W-1:0] lim;
  logic [47:0]      dl;
  logic [47:0]      part;
  logic [79:0]      part_sh;
  logic [55:0]      rpart;
  logic [79:0]      rpart_sh;
  logic [32:0]      tok_sum, need, rdvd;
  logic [31:0]      tok;

  pctbl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ent_r),
    .raddr (iss_idx_r),
    .rdata (rd_data)
  );

  pctbl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign rd_ent    = entry_t'(rd_data);
  assign cap       = {burst_r, 16'h0000};
  assign lpm_full  = ({6'b0, rate_r} << 6) - ({6'b0, rate_r} << 2) + 38'h8000;
  assign rd_v      = valid_r[rd_idx_r];
  assign scan_last = rd_vld_r && (rd_idx_r == LAST_IDX);
  assign ram_we    = (state_r == S_WB);
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // sequencer and datapath
  always_comb begin
    state_nxt  = state_r;
    iss_on_nxt = iss_on_r;
    iss_idx_nxt = iss_idx_r;
    rd_vld_nxt = iss_on_r;
    rd_idx_nxt = iss_idx_r;
    valid_nxt  = valid_r;
    count_nxt  = count_r;
    last_cl_nxt = last_cl_r;
    enable_nxt = enable_r;
    rate_nxt   = rate_r;
    burst_nxt  = burst_r;
    maxent_nxt = maxent_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kh_nxt = kh_r;  kl_nxt = kl_r;  now_nxt = now_r;
    mhit_nxt = mhit_r;  midx_nxt = midx_r;  ment_nxt = ment_r;
    ohit_nxt = ohit_r;  oidx_nxt = oidx_r;  oseen_nxt = oseen_r;
    fhit_nxt = fhit_r;  fidx_nxt = fidx_r;
    ent_nxt = ent_r;  slot_nxt = slot_r;  new_nxt = new_r;  refl_nxt = refl_r;
    dm_nxt = dm_r;  prod_nxt = prod_r;  mstep_nxt = mstep_r;  add_nxt = add_r;
    res_allowed_nxt = res_allowed_r;  res_retry_nxt = res_retry_r;
    res_rem_nxt = res_rem_r;  res_lpm_nxt = res_lpm_r;
    out_allowed_nxt = out_allowed_r;  out_retry_nxt = out_retry_r;
    out_rem_nxt = out_rem_r;  out_lpm_nxt = out_lpm_r;
    div_start = 1'b0;
    div_dividend = '0;
    div_divisor = rate_r;
    evict = 1'b0;
    lim = '0;
    dl = (in_now_ms > last_cl_r) ? (in_now_ms - last_cl_r) : 48'd0;
    part = '0;
    part_sh = '0;
    rpart = '0;
    rpart_sh = '0;
    tok_sum = '0;
    tok = '0;
    need = '0;
    rdvd = '0;

    // address sweep, one read a cycle
    if (iss_on_r) begin
      iss_idx_nxt = iss_idx_r + 1'b1;
      if (iss_idx_r == LAST_IDX) begin
        iss_on_nxt  = 1'b0;
        iss_idx_nxt = '0;
      end
    end

    // configuration writes
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENABLE: enable_nxt = cfg_data[0];
        CFG_RATE:   rate_nxt   = cfg_data;
        CFG_BURST:  burst_nxt  = cfg_data[15:0];
        CFG_MAXENT: maxent_nxt = cfg_data[6:0];
        default:    enable_nxt = enable_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kh_nxt = in_client_key_high;
          kl_nxt = in_client_key_low;
          now_nxt = in_now_ms;
          res_allowed_nxt = 1'b0;
          res_retry_nxt = '0;
          res_rem_nxt = '0;
          res_lpm_nxt = 1'b0;
          mhit_nxt = 1'b0;
          ohit_nxt = 1'b0;
          fhit_nxt = 1'b0;
          if (in_operation == OP_CLEANUP) begin
            if (count_r == '0 || (last_cl_r != '0 && dl < 48'(CLEANUP_PERIOD_MS))) begin
              state_nxt = S_DONE;
            end else begin
              iss_on_nxt = 1'b1;
              iss_idx_nxt = '0;
              state_nxt = S_CL_STALE;
            end
          end else if (!enable_r) begin
            res_allowed_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            res_lpm_nxt = 1'b1;
            iss_on_nxt = 1'b1;
            iss_idx_nxt = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      // lookup sweep: first match, oldest valid entry, first free slot
      S_SCAN: begin
        if (rd_vld_r) begin
          if (rd_v && !mhit_r && rd_ent.key_high == kh_r && rd_ent.key_low == kl_r) begin
            mhit_nxt = 1'b1;
            midx_nxt = rd_idx_r;
            ment_nxt = rd_ent;
          end
          if (rd_v && (!ohit_r || rd_ent.seen_time < oseen_r)) begin
            ohit_nxt = 1'b1;
            oidx_nxt = rd_idx_r;
            oseen_nxt = rd_ent.seen_time;
          end
          if (!rd_v && !fhit_r) begin
            fhit_nxt = 1'b1;
            fidx_nxt = rd_idx_r;
          end
        end
        if (scan_last) begin
          state_nxt = S_PLACE;
        end
      end

      // pick the slot, evicting the oldest entry when the table is at its limit
      S_PLACE: begin
        if (mhit_r) begin
          ent_nxt = ment_r;
          slot_nxt = midx_r;
          new_nxt = 1'b0;
        end else begin
          lim = (maxent_r == '0 || LIM_W'(maxent_r) > LIM_W'(TABLE_DEPTH)) ?
                LIM_W'(TABLE_DEPTH) : LIM_W'(maxent_r);
          evict = (LIM_W'(count_r) >= lim) && ohit_r;
          if (evict) begin
            valid_nxt[oidx_r] = 1'b0;
            count_nxt = count_r - 1'b1;
            slot_nxt = (fhit_r && fidx_r < oidx_r) ? fidx_r : oidx_r;
          end else begin
            slot_nxt = fidx_r;
          end
          ent_nxt = '{key_high: kh_r, key_low: kl_r, tokens: cap,
                      refill_time: now_r, seen_time: now_r};
          new_nxt = 1'b1;
        end
        state_nxt = S_REF;
      end

      // refill only when time has moved on
      S_REF: begin
        refl_nxt = now_r > ent_r.refill_time;
        dm_nxt = now_r - ent_r.refill_time;
        prod_nxt = '0;
        mstep_nxt = '0;
        add_nxt = '0;
        state_nxt = (now_r > ent_r.refill_time) ? S_MUL : S_TOK;
      end

      // rate times elapsed ms, sixteen bits of time a step
      S_MUL: begin
        unique case (mstep_r)
          2'd0: part = rate_r * dm_r[15:0];
          2'd1: part = rate_r * dm_r[31:16];
          default: part = rate_r * dm_r[47:32];
        endcase
        unique case (mstep_r)
          2'd0: part_sh = {32'h0, part};
          2'd1: part_sh = {16'h0, part, 16'h0};
          default: part_sh = {part, 32'h0};
        endcase
        prod_nxt = prod_r + part_sh;
        mstep_nxt = mstep_r + 1'b1;
        if (mstep_r == 2'd2) begin
          state_nxt = S_ADIV;
        end
      end

      // products this large always fill the bucket; otherwise divide by 8 with a shift
      S_ADIV: begin
        if (prod_r[79:64] != '0 || prod_r[63:0] >= REFILL_LIMIT) begin
          add_nxt = cap;
          state_nxt = S_TOK;
        end else begin
          dm_nxt = {9'h0, prod_r[41:3]};
          prod_nxt = '0;
          mstep_nxt = '0;
          state_nxt = S_AWAIT;
        end
      end

      // then divide by 125 through the reciprocal, sixteen bits a step
      S_AWAIT: begin
        unique case (mstep_r)
          2'd0: rpart = MS_RECIP * dm_r[15:0];
          2'd1: rpart = MS_RECIP * dm_r[31:16];
          default: rpart = MS_RECIP * dm_r[47:32];
        endcase
        unique case (mstep_r)
          2'd0: rpart_sh = {24'h0, rpart};
          2'd1: rpart_sh = {8'h0, rpart, 16'h0};
          default: rpart_sh = {rpart[47:0], 32'h0};
        endcase
        if (mstep_r == 2'd3) begin
          add_nxt = (prod_r[79:46] > {2'b00, cap}) ? cap : prod_r[77:46];
          state_nxt = S_TOK;
        end else begin
          prod_nxt = prod_r + rpart_sh;
          mstep_nxt = mstep_r + 1'b1;
        end
      end

      // clamp to capacity, then consume or reject
      S_TOK: begin
        tok_sum = {1'b0, ent_r.tokens} + {1'b0, add_r};
        tok = !refl_r ? ent_r.tokens : ((tok_sum > {1'b0, cap}) ? cap : tok_sum[31:0]);
        ent_nxt.seen_time = now_r;
        if (refl_r) begin
          ent_nxt.refill_time = now_r;
        end
        if ({1'b0, tok} >= ONE_TOKEN) begin
          ent_nxt.tokens = tok - 32'h1_0000;
          res_allowed_nxt = 1'b1;
          res_rem_nxt = ent_nxt.tokens[31:16];
          state_nxt = S_WB;
        end else begin
          ent_nxt.tokens = tok;
          if (rate_r == '0) begin
            res_retry_nxt = 16'd1;
            state_nxt = S_WB;
          end else begin
            need = ONE_TOKEN - {1'b0, tok};
            rdvd = need + {1'b0, rate_r} - 33'd1;
            div_start = 1'b1;
            div_dividend = DIVD_W'(rdvd);
            state_nxt = S_RWAIT;
          end
        end
      end

      S_RWAIT: begin
        if (div_done) begin
          if (div_quot == '0) begin
            res_retry_nxt = 16'd1;
          end else if (div_quot > DIVD_W'(16'hFFFF)) begin
            res_retry_nxt = 16'hFFFF;
          end else begin
            res_retry_nxt = div_quot[15:0];
          end
          state_nxt = S_WB;
        end
      end

      S_WB: begin
        valid_nxt[slot_r] = 1'b1;
        if (new_r) begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = S_DONE;
      end

      // cleanup: drop entries unseen for too long
      S_CL_STALE: begin
        if (rd_vld_r && rd_v && ((now_r - rd_ent.seen_time) > 48'(STALE_LIMIT_MS))) begin
          valid_nxt[rd_idx_r] = 1'b0;
          count_nxt = count_r - 1'b1;
        end
        if (scan_last) begin
          state_nxt = S_CL_CHK;
        end
      end

      S_CL_CHK: begin
        if (LIM_W'(count_r) > LIM_W'(maxent_r)) begin
          ohit_nxt = 1'b0;
          iss_on_nxt = 1'b1;
          iss_idx_nxt = '0;
          state_nxt = S_CL_TRIM;
        end else begin
          last_cl_nxt = now_r;
          state_nxt = S_DONE;
        end
      end

      // cleanup: find the oldest entry to trim
      S_CL_TRIM: begin
        if (rd_vld_r && rd_v && (!ohit_r || rd_ent.seen_time < oseen_r)) begin
          ohit_nxt = 1'b1;
          oidx_nxt = rd_idx_r;
          oseen_nxt = rd_ent.seen_time;
        end
        if (scan_last) begin
          state_nxt = S_CL_EVICT;
        end
      end

      S_CL_EVICT: begin
        if (ohit_r) begin
          valid_nxt[oidx_r] = 1'b0;
          count_nxt = count_r - 1'b1;
        end
        state_nxt = S_CL_CHK;
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_allowed_nxt = res_allowed_r;
          out_retry_nxt = res_retry_r;
          out_rem_nxt = res_rem_r;
          out_lpm_nxt = res_lpm_r ? lpm_full[37:16] : 22'd0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_on_r    <= 1'b0;
      iss_idx_r   <= '0;
      rd_vld_r    <= 1'b0;
      rd_idx_r    <= '0;
      valid_r     <= '0;
      count_r     <= '0;
      last_cl_r   <= '0;
      enable_r    <= 1'b0;
      rate_r      <= '0;
      burst_r     <= '0;
      maxent_r    <= MAX_ENT_RST[6:0];
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_on_r    <= iss_on_nxt;
      iss_idx_r   <= iss_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_idx_r    <= rd_idx_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      last_cl_r   <= last_cl_nxt;
      enable_r    <= enable_nxt;
      rate_r      <= rate_nxt;
      burst_r     <= burst_nxt;
      maxent_r    <= maxent_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kh_r <= kh_nxt;  kl_r <= kl_nxt;  now_r <= now_nxt;
    mhit_r <= mhit_nxt;  midx_r <= midx_nxt;  ment_r <= ment_nxt;
    ohit_r <= ohit_nxt;  oidx_r <= oidx_nxt;  oseen_r <= oseen_nxt;
    fhit_r <= fhit_nxt;  fidx_r <= fidx_nxt;
    ent_r <= ent_nxt;  slot_r <= slot_nxt;  new_r <= new_nxt;  refl_r <= refl_nxt;
    dm_r <= dm_nxt;  prod_r <= prod_nxt;  mstep_r <= mstep_nxt;  add_r <= add_nxt;
    res_allowed_r <= res_allowed_nxt;  res_retry_r <= res_retry_nxt;
    res_rem_r <= res_rem_nxt;  res_lpm_r <= res_lpm_nxt;
    out_allowed_r <= out_allowed_nxt;  out_retry_r <= out_retry_nxt;
    out_rem_r <= out_rem_nxt;  out_lpm_r <= out_lpm_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_allowed          = out_allowed_r;
  assign out_retry_after_s    = out_retry_r;
  assign out_remaining_tokens = out_rem_r;
  assign out_limit_per_minute = out_lpm_r;

  // fill count tracks the valid bits
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r))) else $error("fill count out of step");

  // an allowed item never carries a retry time
  a_allow_retry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_allowed_r |-> out_retry_r == '0) else $error("retry on allowed item");

  // a rejected item with a retry time has no tokens left
  a_reject_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_allowed_r && out_retry_r != '0 |-> out_rem_r == '0)
    else $error("tokens on rejected item");

  // the divider is only waited on while it is running or just finished
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RWAIT) |-> div_busy || div_done)
    else $error("waiting on idle divider");

endmodule

>>> tb/sv/tb_top.sv
// testbench for the per-client token bucket limiter: directed and random items against a predictor
`timescale 1ns / 100ps

module tb_top;
  import pctbl_pkg::*;

  localparam int DEPTH  = 64;
  localparam int STALE  = 300000;
  localparam int PERIOD = 30000;
  localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        allowed;
    logic [15:0] retry;
    logic [15:0] remaining;
    logic [21:0] lpm;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = OP_REQUEST;
  logic [63:0] in_client_key_high = '0;
  logic [63:0] in_client_key_low = '0;
  logic [47:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_allowed;
  logic [15:0] out_retry_after_s;
  logic [15:0] out_remaining_tokens;
  logic [21:0] out_limit_per_minute;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ENABLE;
  logic [31:0] cfg_data = '0;

  per_client_token_bucket_limiter dut (.*);

  // predictor state
  bit          bkt_valid [DEPTH];
  logic [63:0] bkt_kh [DEPTH];
  logic [63:0] bkt_kl [DEPTH];
  logic [31:0] bkt_tokens [DEPTH];
  logic [47:0] bkt_refill [DEPTH];
  logic [47:0] bkt_seen [DEPTH];
  logic [47:0] last_sweep;
  logic        p_enable;
  logic [31:0] p_rate;
  logic [15:0] p_burst;
  logic [6:0]  p_maxent;

  verdict_t    pending_verdicts[$];
  int          mismatches = 0;
  logic [47:0] clock_ms = 48'd1;
  logic [63:0] key_pool_h [16];
  logic [63:0] key_pool_l [16];

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #60ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < DEPTH; i++) if (bkt_valid[i]) n++;
    return n;
  endfunction

  function automatic int stalest_slot();
    int v;
    v = -1;
    for (int i = 0; i < DEPTH; i++)
      if (bkt_valid[i] && (v < 0 || bkt_seen[i] < bkt_seen[v])) v = i;
    return v;
  endfunction

  // sweep stale entries, then trim oldest down to the table limit
  function automatic void sweep_table(logic [47:0] now);
    logic [47:0] d;
    int v;
    if (live_count() == 0) return;
    if (last_sweep != 0) begin
      d = (now > last_sweep) ? now - last_sweep : 48'd0;
      if (d < PERIOD) return;
    end
    for (int i = 0; i < DEPTH; i++)
      if (bkt_valid[i] && ((now - bkt_seen[i]) & MASK48) > STALE) bkt_valid[i] = 0;
    while (live_count() > p_maxent) begin
      v = stalest_slot();
      if (v < 0) break;
      bkt_valid[v] = 0;
    end
    last_sweep = now;
  endfunction

  function automatic verdict_t predict_verdict(logic op, logic [63:0] kh, logic [63:0] kl,
                                               logic [47:0] now);
    verdict_t r;
    logic [63:0] cap, dm, add, t, need, q, rate;
    logic [127:0] prod;
    int s, lim;
    r = '0;
    if (op == OP_CLEANUP) begin
      sweep_table(now);
      return r;
    end
    if (!p_enable) begin
      r.allowed = 1'b1;
      return r;
    end
    cap = 64'(p_burst) << 16;
    rate = 64'(p_rate);
    s = -1;
    for (int i = 0; i < DEPTH; i++)
      if (s < 0 && bkt_valid[i] && bkt_kh[i] == kh && bkt_kl[i] == kl) s = i;
    if (s < 0) begin
      lim = (p_maxent == 0 || p_maxent > DEPTH) ? DEPTH : int'(p_maxent);
      if (live_count() >= lim) begin
        s = stalest_slot();
        if (s >= 0) bkt_valid[s] = 0;
        s = -1;
      end
      for (int i = 0; i < DEPTH; i++) if (s < 0 && !bkt_valid[i]) s = i;
      bkt_valid[s] = 1;
      bkt_kh[s] = kh;
      bkt_kl[s] = kl;
      bkt_tokens[s] = cap[31:0];
      bkt_refill[s] = now;
      bkt_seen[s] = now;
    end
    if (now > bkt_refill[s]) begin
      dm = 64'(now - bkt_refill[s]);
      prod = 128'(rate) * 128'(dm);
      if (prod[127:64] != 0) add = cap;
      else add = prod[63:0] / 1000;
      if (add > cap) add = cap;
      t = 64'(bkt_tokens[s]) + add;
      if (t > cap) t = cap;
      bkt_tokens[s] = t[31:0];
      bkt_refill[s] = now;
    end
    bkt_seen[s] = now;
    q = (rate * 60 + 64'h8000) >> 16;
    r.lpm = q[21:0];
    if (64'(bkt_tokens[s]) >= 64'h10000) begin
      bkt_tokens[s] = bkt_tokens[s] - 32'h10000;
      r.allowed = 1'b1;
      r.remaining = bkt_tokens[s][31:16];
    end else begin
      need = 64'h10000 - 64'(bkt_tokens[s]);
      q = (rate == 0) ? 64'd1 : (need + rate - 1) / rate;
      if (q < 1) q = 1;
      if (q > 65535) q = 65535;
      r.retry = q[15:0];
    end
    return r;
  endfunction

  function automatic int gap_cycles();
    return ($urandom_range(0, 9) < 6) ? 0 :
           ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // sends one item and records what it should produce
  task automatic send_item(logic op, logic [63:0] kh, logic [63:0] kl, logic [47:0] now);
    int n;
    n = gap_cycles();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_client_key_high <= kh;
    in_client_key_low <= kl;
    in_now_ms <= now;
    do @(posedge clk); while (!in_ready);
    pending_verdicts.push_back(predict_verdict(op, kh, kl, now));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLE: p_enable = val[0];
      CFG_RATE:   p_rate = val;
      CFG_BURST:  p_burst = val[15:0];
      default:    p_maxent = val[6:0];
    endcase
  endtask

  task automatic set_all(logic en, logic [31:0] rate, logic [15:0] burst, logic [6:0] me);
    drain();
    write_reg(CFG_ENABLE, 32'(en));
    write_reg(CFG_RATE, rate);
    write_reg(CFG_BURST, 32'(burst));
    write_reg(CFG_MAXENT, 32'(me));
    cfg_valid <= 1'b0;
  endtask

  // result checker with random back-pressure, now and then a long stall
  initial begin
    verdict_t exp;
    verdict_t got;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{out_allowed, out_retry_after_s, out_remaining_tokens, out_limit_per_minute};
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp = pending_verdicts.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p got %p", exp, got);
          end
        end
      end
      if ($urandom_range(0, 99) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 19) == 0);
      end
    end
  end

  task automatic test_disabled();
    send_item(OP_REQUEST, '1, '1, MASK48);
    send_item(OP_REQUEST, '0, '0, 48'd0);
    send_item(OP_CLEANUP, '0, '0, 48'd5);
  endtask

  task automatic test_burst_and_reject();
    set_all(1'b1, 32'h0001_0000, 16'd2, 7'd64);
    repeat (4) send_item(OP_REQUEST, 64'h1, 64'h2, 48'd1000);
    send_item(OP_REQUEST, 64'h1, 64'h2, 48'd1500);
    send_item(OP_REQUEST, 64'h1, 64'h2, 48'd900);
    send_item(OP_REQUEST, 64'h1, 64'h2, 48'd3000);
  endtask

  task automatic test_rate_extremes();
    set_all(1'b1, 32'd0, 16'd1, 7'd64);
    repeat (2) send_item(OP_REQUEST, 64'h5, '1, 48'd10);
    set_all(1'b1, 32'd1, 16'd65535, 7'd64);
    send_item(OP_REQUEST, 64'h9, 64'h9, 48'd10);
    set_all(1'b1, 32'd1, 16'd0, 7'd64);
    send_item(OP_REQUEST, 64'h6, 64'h6, 48'd10);
    set_all(1'b1, 32'hFFFF_FFFF, 16'd3, 7'd64);
    send_item(OP_REQUEST, 64'h7, 64'h7, 48'd10);
    send_item(OP_REQUEST, 64'h7, 64'h7, MASK48);
  endtask

  task automatic test_eviction_and_cleanup();
    set_all(1'b1, 32'h0000_8000, 16'd4, 7'd2);
    for (int i = 0; i < 4; i++) send_item(OP_REQUEST, 64'(i), 64'hA, 48'(2000 + i));
    send_item(OP_CLEANUP, '0, '0, 48'd40000);
    send_item(OP_CLEANUP, '0, '0, 48'd50000);
    send_item(OP_CLEANUP, '0, '0, 48'd500000);
    set_all(1'b1, 32'h0000_8000, 16'd4, 7'd0);
    for (int i = 0; i < 3; i++) send_item(OP_REQUEST, 64'(i), 64'hB, 48'd600000);
    send_item(OP_CLEANUP, '0, '0, 48'd700000);
  endtask

  // random phases over a recycled client pool so buckets are revisited
  task automatic test_random();
    logic [47:0] now;
    int k;
    for (int ph = 0; ph < 6; ph++) begin
      set_all($urandom_range(0, 9) != 0,
              ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0004_0000),
              ($urandom_range(0, 5) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 6)),
              7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 64) : $urandom_range(1, 12)));
      for (int i = 0; i < 125; i++) begin
        case ($urandom_range(0, 19))
          0: clock_ms = clock_ms + $urandom_range(20000, 400000);
          1: now = 48'({$urandom(), $urandom()});
          default: clock_ms = clock_ms + $urandom_range(0, 900);
        endcase
        now = ($urandom_range(0, 29) == 0) ? 48'({$urandom(), $urandom()}) : clock_ms;
        k = $urandom_range(0, 15);
        if ($urandom_range(0, 14) == 0) send_item(OP_CLEANUP, {$urandom(), $urandom()},
                                                 {$urandom(), $urandom()}, now);
        else if ($urandom_range(0, 9) == 0) send_item(OP_REQUEST, {$urandom(), $urandom()},
                                                      {$urandom(), $urandom()}, now);
        else send_item(OP_REQUEST, key_pool_h[k], key_pool_l[k], now);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) bkt_valid[i] = 0;
    last_sweep = '0;
    p_enable = 1'b0;
    p_rate = '0;
    p_burst = '0;
    p_maxent = 7'd64;
    for (int i = 0; i < 16; i++) begin
      key_pool_h[i] = {$urandom(), $urandom()};
      key_pool_l[i] = {$urandom(), $urandom()};
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled();
    test_burst_and_reject();
    test_rate_extremes();
    test_eviction_and_cleanup();
    test_random();
    drain();
    if (mismatches == 0 && pending_verdicts.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pctbl_pkg.sv
rtl/core/pctbl_ram.sv
rtl/core/pctbl_div.sv
rtl/core/per_client_token_bucket_limiter.sv
tb/sv/tb_top.sv
